// ===== src/assert_macros.svh =====
// assertion helpers used by the checker in dtw_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, off while reset is asserted
`define DTW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked property that also holds while reset is asserted
`define DTW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== src/dtw_pkg.sv =====
package dtw_pkg;

  // default sizes of the wheel
  localparam int unsigned WHEEL_SLOTS_DEF  = 256;
  localparam int unsigned SLOT_WAITERS_DEF = 4;
  localparam int unsigned ID_LIMIT_DEF     = 64;

  // fixed field widths
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned ID_W     = 6;
  localparam int unsigned TICKS_W  = 16;
  localparam int unsigned STATUS_W = 2;

  // id compare width, wide enough for the largest id limit
  localparam int unsigned ID_CMP_W = 9;

  // request types
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELAY = 2'd1;

  // reply status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // memory strobes from the sequencer to the slot store
  typedef struct packed {
    logic cnt_re;
    logic cnt_we;
    logic id_re;
    logic id_we;
  } mem_cmd_t;

  // sequencer states
  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_MOD   = 8'b0000_0100,
    S_CRD   = 8'b0000_1000,
    S_CCHK  = 8'b0001_0000,
    S_IRD   = 8'b0010_0000,
    S_IOUT  = 8'b0100_0000,
    S_REPLY = 8'b1000_0000
  } state_e;

endpackage

// ===== src/delay_timer_wheel_top.sv =====
// Timing wheel of delay slots.
// Request channel (in_valid_i / in_stall_o) carries req_type_i, client_id_i and
// ticks_i; a transfer happens when valid is high and stall is low. Result
// channel (out_valid_o / out_stall_i) carries reply_id_o, status_o, last_o.
// One request is worked on at a time; in_stall_o is high until it is done.
// Each request passes through these sequencer steps:
//   invalid type, bad id or non-positive delay: one result
//   tick: a count read, the slot is emptied, then each parked waiter
//   gets one id memory read and one result load, then the acknowledge
//   positive delay: a modulo and a count read, then the id is parked with
//   no result, or the reply goes out if the slot is full
// The delay path runs through the modulo unit, a reciprocal multiply and
// then a multiply-subtract, each registered, then a count read and write
// back; the tick path through the id memory, read once per released waiter.
// After reset the slot count memory is cleared, slot by slot, while
// in_stall_o stays high.
// A stalled result holds in the output register; the request side is still
// accepted meanwhile, and work halts only where a new result must be loaded.
module delay_timer_wheel_top #(
  parameter int unsigned WHEEL_SLOTS  = dtw_pkg::WHEEL_SLOTS_DEF,
  parameter int unsigned SLOT_WAITERS = dtw_pkg::SLOT_WAITERS_DEF,
  parameter int unsigned ID_LIMIT     = dtw_pkg::ID_LIMIT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [dtw_pkg::REQ_W-1:0]           req_type_i,
  input  logic [dtw_pkg::ID_W-1:0]            client_id_i,
  input  logic signed [dtw_pkg::TICKS_W-1:0]  ticks_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [dtw_pkg::ID_W-1:0]            reply_id_o,
  output logic [dtw_pkg::STATUS_W-1:0]        status_o,
  output logic                                last_o
);

  localparam int unsigned SLOT_W = $clog2(WHEEL_SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOT_WAITERS + 1);
  localparam int unsigned IDX_W  = (SLOT_WAITERS > 1) ? $clog2(SLOT_WAITERS) : 1;

  logic                           mod_start;
  logic [dtw_pkg::TICKS_W-1:0]    mod_raw;
  logic                           mod_done;
  logic [SLOT_W-1:0]              mod_rem;
  dtw_pkg::mem_cmd_t              mem_cmd;
  logic [SLOT_W-1:0]              cnt_addr;
  logic [CNT_W-1:0]               cnt_wdata;
  logic [CNT_W-1:0]               cnt_rdata;
  logic [SLOT_W+IDX_W-1:0]        id_addr;
  logic [dtw_pkg::ID_W-1:0]       id_wdata;
  logic [dtw_pkg::ID_W-1:0]       id_rdata;

  // request sequencer and result register
  dtw_ctrl #(
    .WHEEL_SLOTS  (WHEEL_SLOTS),
    .SLOT_WAITERS (SLOT_WAITERS),
    .ID_LIMIT     (ID_LIMIT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .client_id_i (client_id_i),
    .ticks_i     (ticks_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .reply_id_o  (reply_id_o),
    .status_o    (status_o),
    .last_o      (last_o),
    .mod_start_o (mod_start),
    .mod_raw_o   (mod_raw),
    .mod_done_i  (mod_done),
    .mod_rem_i   (mod_rem),
    .mem_cmd_o   (mem_cmd),
    .cnt_addr_o  (cnt_addr),
    .cnt_wdata_o (cnt_wdata),
    .cnt_rdata_i (cnt_rdata),
    .id_addr_o   (id_addr),
    .id_wdata_o  (id_wdata),
    .id_rdata_i  (id_rdata)
  );

  // tick count modulo wheel size
  dtw_mod #(
    .WHEEL_SLOTS (WHEEL_SLOTS)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .raw_i   (mod_raw),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  // slot counts and parked ids
  dtw_store #(
    .WHEEL_SLOTS  (WHEEL_SLOTS),
    .SLOT_WAITERS (SLOT_WAITERS)
  ) u_store (
    .clk_i       (clk_i),
    .cmd_i       (mem_cmd),
    .cnt_addr_i  (cnt_addr),
    .cnt_wdata_i (cnt_wdata),
    .cnt_rdata_o (cnt_rdata),
    .id_addr_i   (id_addr),
    .id_wdata_i  (id_wdata),
    .id_rdata_o  (id_rdata)
  );

endmodule

// ===== src/dtw_mod.sv =====
module dtw_mod #(
  parameter int unsigned WHEEL_SLOTS = dtw_pkg::WHEEL_SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [dtw_pkg::TICKS_W-1:0]     raw_i,
  output logic                            done_o,
  output logic [$clog2(WHEEL_SLOTS)-1:0]  rem_o
);

  localparam int unsigned SLOT_W  = $clog2(WHEEL_SLOTS);
  localparam int unsigned SHIFT   = dtw_pkg::TICKS_W + SLOT_W;
  localparam int unsigned RECIP_W = dtw_pkg::TICKS_W + 2;
  localparam int unsigned PROD_W  = dtw_pkg::TICKS_W + RECIP_W;
  localparam int unsigned QUO_W   = PROD_W - SHIFT;
  localparam int unsigned DW      = dtw_pkg::TICKS_W + 1;

  // rounded-up reciprocal, exact quotient for every dividend of the field width
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(WHEEL_SLOTS) - 64'd1) / 64'(WHEEL_SLOTS);
  localparam logic [PROD_W-1:0] RECIP_X = PROD_W'(RECIP);
  localparam logic [DW-1:0]     SLOTS_X = DW'(WHEEL_SLOTS);

  logic                        busy_q;
  logic                        done_q;
  logic [dtw_pkg::TICKS_W-1:0] raw_q;
  logic [PROD_W-1:0]           prod_q;
  logic [SLOT_W-1:0]           rem_q;
  logic [QUO_W-1:0]            quo;
  logic [DW-1:0]               back;
  logic [DW-1:0]               diff;

  // quotient, then dividend minus quotient times wheel size
  assign quo  = prod_q[PROD_W-1:SHIFT];
  assign back = DW'(quo) * SLOTS_X;
  assign diff = {1'b0, raw_q} - back;

  // step control: product stage, then remainder stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= start_i;
      done_q <= busy_q;
    end
  end

  // dividend, reciprocal product and remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      raw_q  <= raw_i;
      prod_q <= PROD_W'(raw_i) * RECIP_X;
    end
    if (busy_q) begin
      rem_q <= diff[SLOT_W-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== src/dtw_store.sv =====
module dtw_store #(
  parameter int unsigned WHEEL_SLOTS  = dtw_pkg::WHEEL_SLOTS_DEF,
  parameter int unsigned SLOT_WAITERS = dtw_pkg::SLOT_WAITERS_DEF
) (
  input  logic                                  clk_i,
  input  dtw_pkg::mem_cmd_t                     cmd_i,
  input  logic [$clog2(WHEEL_SLOTS)-1:0]        cnt_addr_i,
  input  logic [$clog2(SLOT_WAITERS+1)-1:0]     cnt_wdata_i,
  output logic [$clog2(SLOT_WAITERS+1)-1:0]     cnt_rdata_o,
  input  logic [$clog2(WHEEL_SLOTS)
                + ((SLOT_WAITERS > 1) ? $clog2(SLOT_WAITERS) : 1) - 1:0] id_addr_i,
  input  logic [dtw_pkg::ID_W-1:0]              id_wdata_i,
  output logic [dtw_pkg::ID_W-1:0]              id_rdata_o
);

  localparam int unsigned CNT_W    = $clog2(SLOT_WAITERS + 1);
  localparam int unsigned IDX_W    = (SLOT_WAITERS > 1) ? $clog2(SLOT_WAITERS) : 1;
  localparam int unsigned ID_DEPTH = WHEEL_SLOTS << IDX_W;

  logic [CNT_W-1:0]          cnt_mem [WHEEL_SLOTS];
  logic [dtw_pkg::ID_W-1:0]  id_mem  [ID_DEPTH];
  logic [CNT_W-1:0]          cnt_rdata_q;
  logic [dtw_pkg::ID_W-1:0]  id_rdata_q;

  // waiter count per slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_we) begin
      cnt_mem[cnt_addr_i] <= cnt_wdata_i;
    end
    if (cmd_i.cnt_re) begin
      cnt_rdata_q <= cnt_mem[cnt_addr_i];
    end
  end

  // parked ids, one row of entries per slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.id_we) begin
      id_mem[id_addr_i] <= id_wdata_i;
    end
    if (cmd_i.id_re) begin
      id_rdata_q <= id_mem[id_addr_i];
    end
  end

  assign cnt_rdata_o = cnt_rdata_q;
  assign id_rdata_o  = id_rdata_q;

endmodule

// ===== src/dtw_ctrl.sv =====
module dtw_ctrl #(
  parameter int unsigned WHEEL_SLOTS  = dtw_pkg::WHEEL_SLOTS_DEF,
  parameter int unsigned SLOT_WAITERS = dtw_pkg::SLOT_WAITERS_DEF,
  parameter int unsigned ID_LIMIT     = dtw_pkg::ID_LIMIT_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // request channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [dtw_pkg::REQ_W-1:0]             req_type_i,
  input  logic [dtw_pkg::ID_W-1:0]              client_id_i,
  input  logic signed [dtw_pkg::TICKS_W-1:0]    ticks_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [dtw_pkg::ID_W-1:0]              reply_id_o,
  output logic [dtw_pkg::STATUS_W-1:0]          status_o,
  output logic                                  last_o,
  // modulo unit
  output logic                                  mod_start_o,
  output logic [dtw_pkg::TICKS_W-1:0]           mod_raw_o,
  input  logic                                  mod_done_i,
  input  logic [$clog2(WHEEL_SLOTS)-1:0]        mod_rem_i,
  // slot store
  output dtw_pkg::mem_cmd_t                     mem_cmd_o,
  output logic [$clog2(WHEEL_SLOTS)-1:0]        cnt_addr_o,
  output logic [$clog2(SLOT_WAITERS+1)-1:0]     cnt_wdata_o,
  input  logic [$clog2(SLOT_WAITERS+1)-1:0]     cnt_rdata_i,
  output logic [$clog2(WHEEL_SLOTS)
                + ((SLOT_WAITERS > 1) ? $clog2(SLOT_WAITERS) : 1) - 1:0] id_addr_o,
  output logic [dtw_pkg::ID_W-1:0]              id_wdata_o,
  input  logic [dtw_pkg::ID_W-1:0]              id_rdata_i
);

  localparam int unsigned SLOT_W = $clog2(WHEEL_SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOT_WAITERS + 1);
  localparam int unsigned IDX_W  = (SLOT_WAITERS > 1) ? $clog2(SLOT_WAITERS) : 1;

  dtw_pkg::state_e                state_q, state_d;
  logic [SLOT_W-1:0]              pos_q, pos_d;
  logic [SLOT_W-1:0]              slot_q, slot_d;
  logic [SLOT_W-1:0]              clr_q, clr_d;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic                           tick_q, tick_d;
  logic [dtw_pkg::ID_W-1:0]       req_id_q, req_id_d;
  logic [dtw_pkg::STATUS_W-1:0]   rep_status_q, rep_status_d;
  logic                           out_valid_q, out_valid_d;
  logic [dtw_pkg::ID_W-1:0]       out_id_q, out_id_d;
  logic [dtw_pkg::STATUS_W-1:0]   out_status_q, out_status_d;
  logic                           out_last_q, out_last_d;

  logic                           out_free;
  logic [SLOT_W-1:0]              pos_inc;
  logic [SLOT_W:0]                sum;
  logic [SLOT_W:0]                sum_wrap;
  logic [SLOT_W-1:0]              slot_sum;
  logic                           ticks_pos;
  logic                           id_bad;
  logic [CNT_W-1:0]               cnt_dec;

  // output register is free when empty or being taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // wheel position after a tick
  assign pos_inc = (pos_q == SLOT_W'(WHEEL_SLOTS - 1)) ? '0 : pos_q + 1'b1;

  // target slot: position plus reduced tick count, wrapped once
  assign sum      = {1'b0, pos_q} + {1'b0, mod_rem_i};
  assign sum_wrap = sum - (SLOT_W + 1)'(WHEEL_SLOTS);
  assign slot_sum = (sum >= (SLOT_W + 1)'(WHEEL_SLOTS)) ? sum_wrap[SLOT_W-1:0]
                                                       : sum[SLOT_W-1:0];

  assign ticks_pos = !ticks_i[dtw_pkg::TICKS_W-1] && (ticks_i != '0);
  assign id_bad    = (dtw_pkg::ID_CMP_W'(client_id_i) >= dtw_pkg::ID_CMP_W'(ID_LIMIT));
  assign cnt_dec   = cnt_q - 1'b1;

  // sequencer
  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    slot_d       = slot_q;
    clr_d        = clr_q;
    cnt_d        = cnt_q;
    tick_d       = tick_q;
    req_id_d     = req_id_q;
    rep_status_d = rep_status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_id_d     = out_id_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    mod_start_o  = 1'b0;
    mem_cmd_o    = '0;
    cnt_addr_o   = slot_q;
    cnt_wdata_o  = '0;
    id_addr_o    = {slot_q, IDX_W'(cnt_dec)};
    id_wdata_o   = req_id_q;

    unique case (state_q)
      dtw_pkg::S_CLEAR: begin
        mem_cmd_o.cnt_we = 1'b1;
        cnt_addr_o       = clr_q;
        clr_d            = clr_q + 1'b1;
        if (clr_q == SLOT_W'(WHEEL_SLOTS - 1)) begin
          state_d = dtw_pkg::S_IDLE;
        end
      end
      dtw_pkg::S_IDLE: begin
        if (in_valid_i) begin
          req_id_d = client_id_i;
          unique case (req_type_i)
            dtw_pkg::REQ_TICK: begin
              pos_d        = pos_inc;
              slot_d       = pos_inc;
              tick_d       = 1'b1;
              rep_status_d = dtw_pkg::ST_OK;
              state_d      = dtw_pkg::S_CRD;
            end
            dtw_pkg::REQ_DELAY: begin
              if (id_bad) begin
                rep_status_d = dtw_pkg::ST_INVALID;
                state_d      = dtw_pkg::S_REPLY;
              end else if (!ticks_pos) begin
                rep_status_d = dtw_pkg::ST_OK;
                state_d      = dtw_pkg::S_REPLY;
              end else begin
                mod_start_o = 1'b1;
                tick_d      = 1'b0;
                state_d     = dtw_pkg::S_MOD;
              end
            end
            default: begin
              rep_status_d = dtw_pkg::ST_INVALID;
              state_d      = dtw_pkg::S_REPLY;
            end
          endcase
        end
      end
      dtw_pkg::S_MOD: begin
        if (mod_done_i) begin
          slot_d  = slot_sum;
          state_d = dtw_pkg::S_CRD;
        end
      end
      dtw_pkg::S_CRD: begin
        mem_cmd_o.cnt_re = 1'b1;
        state_d          = dtw_pkg::S_CCHK;
      end
      dtw_pkg::S_CCHK: begin
        if (tick_q) begin
          // empty the slot, then release its waiters newest first
          mem_cmd_o.cnt_we = 1'b1;
          cnt_d            = cnt_rdata_i;
          state_d          = (cnt_rdata_i == '0) ? dtw_pkg::S_REPLY : dtw_pkg::S_IRD;
        end else if (cnt_rdata_i >= CNT_W'(SLOT_WAITERS)) begin
          rep_status_d = dtw_pkg::ST_FULL;
          state_d      = dtw_pkg::S_REPLY;
        end else begin
          // park the id behind the waiters already in the slot
          mem_cmd_o.id_we  = 1'b1;
          mem_cmd_o.cnt_we = 1'b1;
          id_addr_o        = {slot_q, IDX_W'(cnt_rdata_i)};
          cnt_wdata_o      = CNT_W'(cnt_rdata_i + 1'b1);
          state_d          = dtw_pkg::S_IDLE;
        end
      end
      dtw_pkg::S_IRD: begin
        mem_cmd_o.id_re = 1'b1;
        cnt_d           = cnt_dec;
        state_d         = dtw_pkg::S_IOUT;
      end
      dtw_pkg::S_IOUT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_id_d     = id_rdata_i;
          out_status_d = dtw_pkg::ST_OK;
          out_last_d   = 1'b0;
          state_d      = (cnt_q == '0) ? dtw_pkg::S_REPLY : dtw_pkg::S_IRD;
        end
      end
      dtw_pkg::S_REPLY: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_id_d     = req_id_q;
          out_status_d = rep_status_q;
          out_last_d   = 1'b1;
          state_d      = dtw_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dtw_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dtw_pkg::S_CLEAR;
      pos_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // per-request working registers and result payload
  always_ff @(posedge clk_i) begin
    slot_q       <= slot_d;
    cnt_q        <= cnt_d;
    tick_q       <= tick_d;
    req_id_q     <= req_id_d;
    rep_status_q <= rep_status_d;
    out_id_q     <= out_id_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign in_stall_o  = (state_q != dtw_pkg::S_IDLE);
  assign mod_raw_o   = ticks_i;
  assign out_valid_o = out_valid_q;
  assign reply_id_o  = out_id_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

endmodule

// ===== src/dtw_checker.sv =====
`include "assert_macros.svh"

module dtw_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic [dtw_pkg::REQ_W-1:0]           req_type_i,
  input logic [dtw_pkg::ID_W-1:0]            client_id_i,
  input logic signed [dtw_pkg::TICKS_W-1:0]  ticks_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [dtw_pkg::ID_W-1:0]            reply_id_o,
  input logic [dtw_pkg::STATUS_W-1:0]        status_o,
  input logic                                last_o
);

  // a stalled result holds
  `DTW_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(reply_id_o) && $stable(status_o) && $stable(last_o), "stalled result changed")

  // only defined status codes leave the block
  `DTW_ASSERT(a_status_code, clk_i, rst_ni, out_valid_o |-> (status_o == dtw_pkg::ST_OK || status_o == dtw_pkg::ST_INVALID || status_o == dtw_pkg::ST_FULL), "undefined status code")

  // released waiters always report success, errors end their request
  `DTW_ASSERT(a_release_ok, clk_i, rst_ni, out_valid_o && !last_o |-> status_o == dtw_pkg::ST_OK, "non-final result with error status")

  // one request at a time: a transfer closes the request port
  `DTW_ASSERT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o, "request taken while busy")

  // reset empties the result register and blocks requests
  `DTW_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o && in_stall_o, "activity during reset")

endmodule

bind delay_timer_wheel_top dtw_checker u_dtw_checker (.*);

// ===== verif/delay_timer_wheel_checker.sv =====
`timescale 1ns / 1ps

module delay_timer_wheel_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_o,
  input  logic [dtw_pkg::REQ_W-1:0]           req_type_i,
  input  logic [dtw_pkg::ID_W-1:0]            client_id_i,
  input  logic [dtw_pkg::TICKS_W-1:0]         ticks_i,
  input  logic                                out_valid_o,
  input  logic                                out_stall_i,
  input  logic [dtw_pkg::ID_W-1:0]            reply_id_o,
  input  logic [dtw_pkg::STATUS_W-1:0]        status_o,
  input  logic                                last_o,
  output int                                  due_cnt_o,
  output int                                  err_cnt_o
);
  import dtw_pkg::*;

  localparam int MAX_PRINTED = 50;

  // one reply as it leaves the block
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [STATUS_W-1:0] status;
    logic                last;
  } reply_t;

  // shadow copy of the wheel
  int unsigned     wheel_pos;
  int unsigned     slot_fill  [WHEEL_SLOTS_DEF];
  logic [ID_W-1:0] parked_ids [WHEEL_SLOTS_DEF][SLOT_WAITERS_DEF];
  reply_t          replies_due[$];

  initial begin
    err_cnt_o = 0;
  end

  // print one line per mismatch, up to MAX_PRINTED of them, and count every one
  task automatic report_mismatch(input string what);
    if (err_cnt_o < MAX_PRINTED)
      $display("%0t ns: mismatch: %s", $time, what);
    err_cnt_o++;
  endtask

  // work out the replies that one request transfer causes
  function automatic void predict_replies(input logic [REQ_W-1:0]   kind,
                                          input logic [ID_W-1:0]    id,
                                          input logic [TICKS_W-1:0] dly);
    int unsigned slot;
    int unsigned n;
    if (kind == REQ_TICK) begin
      slot = (wheel_pos + 1) % WHEEL_SLOTS_DEF;
      wheel_pos = slot;
      // newest waiter leaves first
      for (n = slot_fill[slot]; n > 0; n--)
        replies_due.push_back({parked_ids[slot][n-1], ST_OK, 1'b0});
      slot_fill[slot] = 0;
      replies_due.push_back({id, ST_OK, 1'b1});
    end else if (kind == REQ_DELAY) begin
      if (int'(id) >= int'(ID_LIMIT_DEF)) begin
        replies_due.push_back({id, ST_INVALID, 1'b1});
      end else if (dly[TICKS_W-1] || dly == '0) begin
        // zero or negative delay is answered at once
        replies_due.push_back({id, ST_OK, 1'b1});
      end else begin
        slot = (wheel_pos + dly) % WHEEL_SLOTS_DEF;
        if (slot_fill[slot] >= SLOT_WAITERS_DEF) begin
          replies_due.push_back({id, ST_FULL, 1'b1});
        end else begin
          parked_ids[slot][slot_fill[slot]] = id;
          slot_fill[slot]++;
        end
      end
    end else begin
      replies_due.push_back({id, ST_INVALID, 1'b1});
    end
  endfunction

  // watch both channels: compare result transfers, predict on request transfers
  always @(posedge clk_i or negedge rst_ni) begin : watch
    reply_t got;
    reply_t want;
    if (!rst_ni) begin
      wheel_pos = 0;
      foreach (slot_fill[s]) slot_fill[s] = 0;
      replies_due.delete();
      due_cnt_o <= 0;
    end else begin
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        got = {reply_id_o, status_o, last_o};
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result id %0d status %0d last %0b",
                                    got.id, got.status, got.last));
        end else begin
          want = replies_due.pop_front();
          if (got.id !== want.id)
            report_mismatch($sformatf("reply_id %0d, expected %0d", got.id, want.id));
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d (id %0d)",
                                      got.status, want.status, want.id));
          if (got.last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b (id %0d)",
                                      got.last, want.last, want.id));
        end
      end
      if (in_valid_i === 1'b1 && in_stall_o === 1'b0)
        predict_replies(req_type_i, client_id_i, ticks_i);
      due_cnt_o <= replies_due.size();
    end
  end

endmodule

// ===== verif/delay_timer_wheel_top_tb.sv =====
`timescale 1ns / 1ps

module delay_timer_wheel_top_tb;
  import dtw_pkg::*;

  // request types that the block must reject
  localparam logic [REQ_W-1:0] REQ_BAD_LO = 2'd2;
  localparam logic [REQ_W-1:0] REQ_BAD_HI = 2'd3;

  localparam int LONG_HOLD   = 80;
  localparam int RAND_ITEMS  = 150;
  localparam int CALM_ITEMS  = 30;
  localparam int HOLD_AT     = 40;
  localparam int DRAIN_AT    = 90;
  localparam int TAIL_CYCLES = 40;
  localparam int TIMEOUT_NS  = 4_000_000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [REQ_W-1:0]    req_type_i;
  logic [ID_W-1:0]     client_id_i;
  logic [TICKS_W-1:0]  ticks_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [ID_W-1:0]     reply_id_o;
  logic [STATUS_W-1:0] status_o;
  logic                last_o;

  int due_cnt;
  int err_cnt;
  bit long_hold_req = 1'b0;
  bit bursts_on     = 1'b1;

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  delay_timer_wheel_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .client_id_i (client_id_i),
    .ticks_i     (ticks_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .reply_id_o  (reply_id_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  delay_timer_wheel_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .client_id_i (client_id_i),
    .ticks_i     (ticks_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .reply_id_o  (reply_id_o),
    .status_o    (status_o),
    .last_o      (last_o),
    .due_cnt_o   (due_cnt),
    .err_cnt_o   (err_cnt)
  );

  // offer one request and return at the edge of its transfer
  task automatic send_req(input logic [REQ_W-1:0]   kind,
                          input logic [ID_W-1:0]    id,
                          input logic [TICKS_W-1:0] dly);
    in_valid_i  <= 1'b1;
    req_type_i  <= kind;
    client_id_i <= id;
    ticks_i     <= dly;
    do @(negedge clk_i); while (in_stall_o !== 1'b0);
    @(posedge clk_i);
  endtask

  // sender idle burst
  task automatic idle_gap();
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 7)) @(posedge clk_i);
  endtask

  // stop offering until every predicted reply has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (due_cnt != 0);
    @(posedge clk_i);
  endtask

  // result side: random stall bursts and one long hold-off
  initial begin : result_sink
    int n;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        for (n = 0; n < LONG_HOLD; n++) @(posedge clk_i);
        out_stall_i <= 1'b0;
        long_hold_req = 1'b0;
      end else if (bursts_on && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // request side
  initial begin : stimulus
    int               k;
    int               pick;
    logic [REQ_W-1:0] kind;
    logic [ID_W-1:0]  id;
    logic [TICKS_W-1:0] dly;

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    req_type_i  <= REQ_TICK;
    client_id_i <= '0;
    ticks_i     <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // invalid types, with extreme ids and tick counts
    send_req(REQ_BAD_LO, 6'd0, 16'h0000);
    send_req(REQ_BAD_HI, 6'd63, 16'hFFFF);
    // zero and negative delays are answered at once
    send_req(REQ_DELAY, 6'd5, 16'h0000);
    send_req(REQ_DELAY, 6'd6, 16'hFFFF);
    send_req(REQ_DELAY, 6'd7, 16'h8000);
    // fill slot 1 through aliased counts, then overflow it
    send_req(REQ_DELAY, 6'd63, 16'd1);
    send_req(REQ_DELAY, 6'd0, 16'd257);
    send_req(REQ_DELAY, 6'd42, 16'd513);
    idle_gap();
    send_req(REQ_DELAY, 6'd21, 16'd769);
    send_req(REQ_DELAY, 6'd33, 16'd32513);
    // largest positive count lands in the last slot
    send_req(REQ_DELAY, 6'd9, 16'h7FFF);
    // tick into the full slot releases four, then one into an empty slot
    send_req(REQ_TICK, 6'd1, 16'h5555);
    send_req(REQ_TICK, 6'd62, 16'hAAAA);
    // two waiters in one slot, released newest first
    send_req(REQ_DELAY, 6'd12, 16'd1);
    send_req(REQ_DELAY, 6'd13, 16'h0101);
    send_req(REQ_DELAY, 6'd14, 16'h2AAA);
    send_req(REQ_DELAY, 6'd15, 16'h5555);
    send_req(REQ_TICK, 6'd40, 16'h0000);
    send_req(REQ_TICK, 6'd41, 16'hFFFF);
    wait_drained();

    // random part: mostly short delays against ticks so slots fill and overflow
    for (k = 0; k < RAND_ITEMS; k++) begin
      if (k == HOLD_AT) long_hold_req = 1'b1;
      if (k == DRAIN_AT) wait_drained();
      if (k == RAND_ITEMS - CALM_ITEMS) bursts_on = 1'b0;
      pick = $urandom_range(0, 99);
      id   = ID_W'($urandom);
      dly  = TICKS_W'($urandom);
      if (pick < 20) begin
        kind = REQ_TICK;
      end else if (pick < 80) begin
        kind = REQ_DELAY;
        dly  = TICKS_W'($urandom_range(1, 3) + 256 * $urandom_range(0, 127));
      end else if (pick < 88) begin
        kind = REQ_DELAY;
        dly  = TICKS_W'($urandom_range(1, 32767));
      end else if (pick < 94) begin
        kind = REQ_DELAY;
        dly  = ($urandom_range(0, 3) == 0) ? '0 : {1'b1, 15'($urandom)};
      end else begin
        kind = ($urandom_range(0, 1) == 0) ? REQ_BAD_LO : REQ_BAD_HI;
      end
      send_req(kind, id, dly);
      // no sender gaps while the receiver holds off, so the block backs up
      if (bursts_on && !long_hold_req && $urandom_range(0, 2) == 0)
        idle_gap();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // run limit
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("timeout after %0d ns", TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/dtw_pkg.sv
src/dtw_mod.sv
src/dtw_store.sv
src/dtw_ctrl.sv
src/delay_timer_wheel_top.sv
src/dtw_checker.sv
verif/delay_timer_wheel_checker.sv
verif/delay_timer_wheel_top_tb.sv
